// ===== hdl/running_average_filter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Running average filter assertion macros
// Shared property shorthands for the filter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RUNNING_AVERAGE_FILTER_UNIT_DEFINES_SVH
`define RUNNING_AVERAGE_FILTER_UNIT_DEFINES_SVH

// Check that holds outside reset.
`define RAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that holds at every clock edge, reset included.
`define RAF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/raf_pkg.sv =====
// ----------------------------------------------------------------------------
// Running average filter package
// Types and fixed constants of the running average filter.
// ----------------------------------------------------------------------------
package raf_pkg;

  localparam int unsigned CFG_W = 6;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd20;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_DONE   = 5'b01000,
    ST_SPARE  = 5'b10000
  } raf_state_e;

  typedef struct packed {
    logic start;
    logic done;
  } raf_div_ctrl_t;

endpackage

// ===== hdl/raf_ring.sv =====
// ----------------------------------------------------------------------------
// Running average filter sample ring
// Single-port-write, registered-read storage for the recent samples.
// ----------------------------------------------------------------------------
module raf_ring #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/raf_divider.sv =====
// ----------------------------------------------------------------------------
// Running average filter divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module raf_divider #(
  parameter int unsigned DIVIDEND_W = 22,
  parameter int unsigned DIVISOR_W  = 6,
  parameter int unsigned QUOT_W     = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  raf_pkg::raf_div_ctrl_t ctrl_i,
  output raf_pkg::raf_div_ctrl_t ctrl_o,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [QUOT_W-1:0]     quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  neg_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  divisor_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;
  logic [DIVIDEND_W-1:0] magnitude;
  logic [DIVIDEND_W-1:0] signed_quo;

  assign magnitude = dividend_i[DIVIDEND_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign trial     = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge        = trial >= {1'b0, divisor_q};
  assign diff      = trial - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      neg_q     <= dividend_i[DIVIDEND_W-1];
      quo_q     <= magnitude;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

  assign signed_quo   = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o   = signed_quo[QUOT_W-1:0];
  assign ctrl_o.start = busy_q;
  assign ctrl_o.done  = done_q;

endmodule

// ===== hdl/running_average_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Running average filter unit
// Boxcar moving average over the last N samples, kept in a ring.
// ----------------------------------------------------------------------------
// Each sample request passes through these steps: accept the sample,
// update the running sum and the ring, divide the running sum by the fill
// count in the bit-serial divider, let the divider report completion, and
// hand the result to the output register. The handoff waits while the
// previous result is still held in the output register and not yet taken.
// The input is not ready during that time.
// A write of the window length restarts the filter with an empty window.
module running_average_filter_unit #(
  parameter int unsigned MAX_WINDOW  = 32,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [raf_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // Fields from bit 0: average.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata_o
);

  `include "running_average_filter_unit_defines.svh"

  localparam int unsigned DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned ADDR_W = $clog2(MAX_WINDOW);
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int unsigned LEN_W  = (CNT_W > raf_pkg::CFG_W) ? CNT_W : raf_pkg::CFG_W;

  raf_pkg::raf_state_e       state_q, state_d;
  logic [raf_pkg::CFG_W-1:0] window_q;
  logic [SAMPLE_BITS-1:0]    sample_q;
  logic [ADDR_W-1:0]         ptr_q, ptr_d;
  logic [CNT_W-1:0]          fill_q, fill_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic                      m_valid_q;
  logic [SAMPLE_BITS-1:0]    m_data_q;

  logic [LEN_W-1:0]          win_ext;
  logic [CNT_W-1:0]          win_len;
  logic [CNT_W-1:0]          ptr_inc;
  logic [SAMPLE_BITS-1:0]    ring_rdata;
  logic [SAMPLE_BITS-1:0]    old_sample;
  logic                      in_accept;
  logic                      out_load;
  raf_pkg::raf_div_ctrl_t    div_req;
  raf_pkg::raf_div_ctrl_t    div_rsp;
  logic [SAMPLE_BITS-1:0]    quotient;

  assign win_ext = LEN_W'(window_q);

  always_comb begin
    if (win_ext == '0) begin
      win_len = CNT_W'(1);
    end else if (win_ext > LEN_W'(MAX_WINDOW)) begin
      win_len = CNT_W'(MAX_WINDOW);
    end else begin
      win_len = CNT_W'(win_ext);
    end
  end

  assign s_axis_tready_o = (state_q == raf_pkg::ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == raf_pkg::ST_DONE) && (!m_valid_q || m_axis_tready_i);

  assign old_sample = (fill_q < win_len) ? '0 : ring_rdata;
  assign ptr_inc    = CNT_W'(ptr_q) + 1'b1;

  always_comb begin
    sum_d  = sum_q
           - {{(SUM_W-SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample}
           + {{(SUM_W-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
    ptr_d  = (ptr_inc >= win_len) ? '0 : ptr_inc[ADDR_W-1:0];
    fill_d = (fill_q < win_len) ? fill_q + 1'b1 : fill_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      raf_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = raf_pkg::ST_UPDATE;
        end
      end
      raf_pkg::ST_UPDATE: begin
        state_d = raf_pkg::ST_DIVIDE;
      end
      raf_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_d = raf_pkg::ST_DONE;
        end
      end
      raf_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = raf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = raf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= raf_pkg::ST_IDLE;
      window_q  <= raf_pkg::WINDOW_RESET;
      ptr_q     <= '0;
      fill_q    <= '0;
      sum_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
        ptr_q    <= '0;
        fill_q   <= '0;
        sum_q    <= '0;
      end else if (state_q == raf_pkg::ST_UPDATE) begin
        ptr_q  <= ptr_d;
        fill_q <= fill_d;
        sum_q  <= sum_d;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= s_axis_tdata_i[SAMPLE_BITS-1:0];
    end
    if (out_load) begin
      m_data_q <= quotient;
    end
  end

  raf_ring #(
    .DEPTH  (MAX_WINDOW),
    .WIDTH  (SAMPLE_BITS),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == raf_pkg::ST_UPDATE),
    .addr_i  (ptr_q),
    .wdata_i (sample_q),
    .rdata_o (ring_rdata)
  );

  assign div_req.start = (state_q == raf_pkg::ST_UPDATE);
  assign div_req.done  = 1'b0;

  raf_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W),
    .QUOT_W     (SAMPLE_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_req),
    .ctrl_o     (div_rsp),
    .dividend_i (sum_d),
    .divisor_i  (fill_d),
    .quotient_o (quotient)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = DATA_W'(m_data_q);

  `RAF_ASSERT(a_fill_in_window, fill_q <= win_len, "fill count exceeds window length")
  `RAF_ASSERT(a_ptr_in_window, CNT_W'(ptr_q) < win_len, "write pointer outside window")
  `RAF_ASSERT(a_div_done_state, div_rsp.done |-> state_q == raf_pkg::ST_DIVIDE,
              "divider finished outside the divide phase")
  `RAF_ASSERT_ALWAYS(a_div_idle_ready, s_axis_tready_o |-> !div_rsp.start,
                     "input ready while the divider is busy")

endmodule
